// ===== rtl/pita_pkg.sv =====
// Shared types, character codes and digit helpers for the integer-to-ASCII converter.
`default_nettype none
package pita_pkg;

    localparam int VALUE_W     = 64;
    localparam int MIN_W_W     = 7;
    localparam int CHAR_W      = 7;
    localparam int NUM_DIGITS  = 20;   // decimal digits of the largest 64-bit value
    localparam int DIGIT_CNT_W = 5;
    localparam int BIT_CNT_W   = 6;

    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 7'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 7'h2D;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 7'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
    localparam logic [CHAR_W-1:0] CHAR_NINE    = 7'h39;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 7'h46;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 7'h66;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_CONV = 4'b0010,
        ST_SKIP = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    typedef logic [NUM_DIGITS-1:0][3:0] digits_t;

    // ASCII code of one digit, 0..15
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] d_ext;
        d_ext = {3'b000, d};
        if (d < 4'd10)
            digit_char = CHAR_ZERO + d_ext;
        else if (upper)
            digit_char = CHAR_UPPER_A + d_ext - 7'd10;
        else
            digit_char = CHAR_LOWER_A + d_ext - 7'd10;
    endfunction

    // Double-dabble correction: add 3 to every BCD digit of 5 or more
    function automatic digits_t dabble(input digits_t d);
        digits_t r;
        for (int i = 0; i < NUM_DIGITS; i++)
            r[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
        dabble = r;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/padded_integer_to_ascii.sv =====
// Top level: bit-serial 64-bit integer to padded ASCII character stream.
//
// Input channel (in_valid / in_stall): one item is a 64-bit value plus format
// flags (signed_mode, hex_base, upper_digits, pad_zero) and min_width. An
// item is taken when in_valid is high and in_stall is low. One item is
// converted at a time; in_stall stays high from acceptance until the last
// character of that item has entered the output register.
// Output channel (out_valid / out_stall): one item per character, most
// significant first; last_char marks the final character of the number.
// Steps: a load step (sign and magnitude), 64 steps of shift-and-add-3
// conversion (one value bit per cycle; hex skips the correction), then
// leading zero digits are dropped (20 - digits of them, at most 19) and the
// padding is sized, then one character per cycle while out_stall is low.
// Output stalls: the output register holds its character while out_stall is
// high and the emitter waits; nothing is lost. A new item may be accepted
// while the final character of the previous one still waits.
// Reset (rst_n low, asynchronous): block returns idle, output empty.
// min_width above MAX_WIDTH is clipped to MAX_WIDTH.
`default_nettype none
module padded_integer_to_ascii
    import pita_pkg::*;
#(
    parameter int MAX_WIDTH = 64
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [VALUE_W-1:0] value,
    input  wire logic               signed_mode,
    input  wire logic               hex_base,
    input  wire logic               upper_digits,
    input  wire logic [MIN_W_W-1:0] min_width,
    input  wire logic               pad_zero,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [CHAR_W-1:0]  char_code,
    output      logic               last_char
);

    // control
    state_t                 state_reg, state_next;
    logic [BIT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIGIT_CNT_W-1:0] ndig_reg, ndig_next;
    logic [MIN_W_W-1:0]     pad_reg, pad_next;
    logic                   neg_reg, neg_next;
    logic                   out_valid_reg, out_valid_next;

    // payload
    logic [VALUE_W-1:0]     mag_reg, mag_next;
    digits_t                dig_reg, dig_next;
    logic [MIN_W_W-1:0]     width_reg, width_next;
    logic                   hex_reg, hex_next;
    logic                   upper_reg, upper_next;
    logic                   zero_reg, zero_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic                   load_ok;
    logic [MIN_W_W-1:0]     need;
    digits_t                conv_src;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign char_code = char_reg;
    assign last_char = last_reg;

    // output register free this cycle
    assign load_ok  = !out_valid_reg || !out_stall;
    // characters taken by sign and digits
    assign need     = {{(MIN_W_W-DIGIT_CNT_W){1'b0}}, ndig_reg} + {{(MIN_W_W-1){1'b0}}, neg_reg};
    assign conv_src = hex_reg ? dig_reg : dabble(dig_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ndig_next      = ndig_reg;
        pad_next       = pad_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg && out_stall;
        mag_next       = mag_reg;
        dig_next       = dig_reg;
        width_next     = width_reg;
        hex_next       = hex_reg;
        upper_next     = upper_reg;
        zero_next      = zero_reg;
        char_next      = char_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = signed_mode && value[VALUE_W-1];
                    mag_next   = (signed_mode && value[VALUE_W-1]) ? (~value + 64'd1) : value;
                    dig_next   = '0;
                    cnt_next   = {BIT_CNT_W{1'b1}};
                    ndig_next  = DIGIT_CNT_W'(NUM_DIGITS);
                    width_next = (32'(min_width) > MAX_WIDTH) ? MIN_W_W'(MAX_WIDTH) : min_width;
                    hex_next   = hex_base;
                    upper_next = upper_digits;
                    zero_next  = pad_zero;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                // one value bit per cycle into the digit register
                dig_next = {conv_src[NUM_DIGITS-1][2:0], conv_src[NUM_DIGITS-2:0],
                            mag_reg[VALUE_W-1]};
                mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - BIT_CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_SKIP;
            end
            ST_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if ((ndig_reg > 5'd1) && (dig_reg[NUM_DIGITS-1] == 4'h0))
                begin
                    dig_next  = {dig_reg[NUM_DIGITS-2:0], 4'h0};
                    ndig_next = ndig_reg - DIGIT_CNT_W'(1);
                end
                else
                begin
                    pad_next   = (width_reg > need) ? width_reg - need : '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load_ok)
                begin
                    out_valid_next = 1'b1;
                    last_next      = 1'b0;
                    if (neg_reg && (zero_reg || (pad_reg == '0)))
                    begin
                        char_next = CHAR_MINUS;
                        neg_next  = 1'b0;
                    end
                    else if (pad_reg != '0)
                    begin
                        char_next = zero_reg ? CHAR_ZERO : CHAR_SPACE;
                        pad_next  = pad_reg - MIN_W_W'(1);
                    end
                    else
                    begin
                        char_next = digit_char(dig_reg[NUM_DIGITS-1], upper_reg);
                        dig_next  = {dig_reg[NUM_DIGITS-2:0], 4'h0};
                        ndig_next = ndig_reg - DIGIT_CNT_W'(1);
                        if (ndig_reg == 5'd1)
                        begin
                            last_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ndig_reg      <= '0;
            pad_reg       <= '0;
            neg_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ndig_reg      <= ndig_next;
            pad_reg       <= pad_next;
            neg_reg       <= neg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        dig_reg   <= dig_next;
        width_reg <= width_next;
        hex_reg   <= hex_next;
        upper_reg <= upper_next;
        zero_reg  <= zero_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

endmodule
`default_nettype wire

// ===== rtl/pita_checker.sv =====
// Port-level checker for the integer-to-ASCII converter, with its bind.
`default_nettype none
module pita_checker
    import pita_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_stall,
    input wire logic              out_valid,
    input wire logic              out_stall,
    input wire logic [CHAR_W-1:0] char_code,
    input wire logic              last_char
);

    // stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(char_code) && $stable(last_char))
        else $error("output item changed while stalled");

    // an accepted item keeps the block busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an item");

    // while idle, a pending character can only be the end of a number
    a_idle_pending_last: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall && out_valid |-> last_char)
        else $error("idle with an unfinished number in the output");

    // only digits, hex letters, minus and space
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE))
                   || ((char_code >= CHAR_UPPER_A) && (char_code <= CHAR_UPPER_F))
                   || ((char_code >= CHAR_LOWER_A) && (char_code <= CHAR_LOWER_F))
                   || (char_code == CHAR_MINUS) || (char_code == CHAR_SPACE))
        else $error("illegal character code");

endmodule

bind padded_integer_to_ascii pita_checker u_pita_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .last_char (last_char)
);
`default_nettype wire
